[design/gdr_pkg.sv]
// package for the gyro dead-reckoning integrator
// constants, types and the cordic angle table; no dependencies
package gdr_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned PosWidthDef    = 48;
  localparam int unsigned MaxSteps       = 24;

  localparam logic signed [23:0] BiasXReset = -24'sd90409;
  localparam logic signed [23:0] BiasYReset = 24'sd16745;
  localparam logic signed [23:0] BiasZReset = 24'sd15683;
  localparam logic [31:0]        ScaleReset = 32'd4724464;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // reciprocal of the angle divisor 5625 scaled by 2^59, rounded up
  // exact floor quotient for dividends below 2^46
  localparam int unsigned RecipShift = 59;
  localparam logic [47:0] Recip      = 48'((64'd1 << RecipShift) / 64'd5625 + 64'd1);

  localparam logic [1:0] RegBiasX = 2'd0;
  localparam logic [1:0] RegBiasY = 2'd1;
  localparam logic [1:0] RegBiasZ = 2'd2;
  localparam logic [1:0] RegScale = 2'd3;

  // one item as it crosses from front to back
  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] distance;
    logic [19:0]        elapsed_us;
  } item_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
      5'd20: r = 32'd652;        5'd21: r = 32'd326;
      5'd22: r = 32'd163;        5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[design/gyro_dead_reckoning_integrator_top.sv]
// top level of the gyro dead-reckoning integrator
// one request in the back end, which takes a new one only once the last result is taken;
// each runs three angle updates (multiply, reciprocal divide, add) and then the cordic;
// the two-entry input queue accepts while the back end works; reset clears angles, positions
// and restores default bias and scale; depends on gdr_pkg, gdr_front, gdr_back
module gyro_dead_reckoning_integrator_top #(
  parameter int unsigned CORDIC_STEPS = gdr_pkg::CordicStepsDef,
  parameter int unsigned POS_WIDTH    = gdr_pkg::PosWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic signed [15:0] distance_i,
  input  logic [19:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic [31:0] heading_o,
  output logic [31:0] tilt_pitch_o,
  output logic [31:0] tilt_roll_o
);

  // configuration registers
  logic signed [23:0] bias_x_q, bias_y_q, bias_z_q;
  logic [31:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q <= gdr_pkg::BiasXReset;
      bias_y_q <= gdr_pkg::BiasYReset;
      bias_z_q <= gdr_pkg::BiasZReset;
      scale_q  <= gdr_pkg::ScaleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gdr_pkg::RegBiasX: bias_x_q <= cfg_data_i[23:0];
        gdr_pkg::RegBiasY: bias_y_q <= cfg_data_i[23:0];
        gdr_pkg::RegBiasZ: bias_z_q <= cfg_data_i[23:0];
        default:           scale_q  <= cfg_data_i;
      endcase
    end
  end

  gdr_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [47:0] px, py;

  assign in_item = '{rate_x: rate_x_i, rate_y: rate_y_i, rate_z: rate_z_i,
                     distance: distance_i, elapsed_us: elapsed_us_i};

  // front end: input queue
  gdr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  // back end: integration, cordic and position update
  gdr_back #(.CordicSteps(CORDIC_STEPS), .PosWidth(POS_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .bias_x_i(bias_x_q), .bias_y_i(bias_y_q), .bias_z_i(bias_z_q), .scale_i(scale_q),
    .out_valid_o, .out_ready_i, .pos_x_o(px), .pos_y_o(py),
    .heading_o, .tilt_pitch_o, .tilt_roll_o
  );

  assign pos_x_o = px;
  assign pos_y_o = py;

endmodule

[design/gdr_front.sv]
// front: accepts items into a two-entry queue
// depends on gdr_pkg
module gdr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gdr_pkg::item_t  item_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output gdr_pkg::item_t  q_item_o
);

  gdr_pkg::item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = q_valid_o & q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/gdr_back.sv]
// back: angle integration, iterative cordic and position update
// depends on gdr_pkg
module gdr_back #(
  parameter int unsigned CordicSteps = gdr_pkg::CordicStepsDef,
  parameter int unsigned PosWidth    = gdr_pkg::PosWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  gdr_pkg::item_t     q_item_i,
  input  logic signed [23:0] bias_x_i,
  input  logic signed [23:0] bias_y_i,
  input  logic signed [23:0] bias_z_i,
  input  logic [31:0]        scale_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        pos_x_o,
  output logic [47:0]        pos_y_o,
  output logic [31:0]        heading_o,
  output logic [31:0]        tilt_pitch_o,
  output logic [31:0]        tilt_roll_o
);

  localparam int unsigned Steps = (CordicSteps < gdr_pkg::MaxSteps) ?
                                  CordicSteps : gdr_pkg::MaxSteps;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_ANG, S_CORD, S_PMUL, S_PSH, S_ADD, S_OUT
  } state_e;

  state_e state_q;
  gdr_pkg::item_t it_q;
  logic [1:0]  ax_q;                 // axis being integrated
  logic [5:0]  bit_q;                // divide step / cordic step
  logic signed [45:0] p_q;           // 2*r*t
  logic [45:0] nn_q;                 // rounded dividend
  logic [92:0] acc_q;                // dividend times reciprocal
  logic [31:0] yaw_q, pitch_q, roll_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic signed [31:0] m_q;
  logic signed [65:0] px_q, py_q;
  logic signed [PosWidth-1:0] posx_q, posy_q;
  logic [47:0] ox_q, oy_q;

  logic signed [23:0] bias_sel;
  logic signed [15:0] rate_sel;
  logic signed [24:0] r_val;
  logic [45:0] mag;
  logic [15:0] rchunk;
  logic [92:0] acc_nx;
  logic [31:0] quo;
  logic [31:0] delta;
  logic [31:0] cur_ang, atn;
  logic signed [33:0] xs, ys;
  logic signed [65:0] dx, dy;
  logic signed [PosWidth-1:0] nx, ny;

  always_comb begin
    unique case (ax_q)
      2'd0: begin bias_sel = bias_z_i; rate_sel = it_q.rate_z; cur_ang = yaw_q; end
      2'd1: begin bias_sel = bias_x_i; rate_sel = it_q.rate_x; cur_ang = pitch_q; end
      default: begin bias_sel = bias_y_i; rate_sel = it_q.rate_y; cur_ang = roll_q; end
    endcase
    r_val = {rate_sel[15], rate_sel, 8'd0} - {bias_sel[23], bias_sel};
    mag = p_q[45] ? 46'(-p_q) : 46'(p_q);
    // reciprocal taken 16 bits at a time, top chunk first
    unique case (bit_q[1:0])
      2'd1: rchunk = gdr_pkg::Recip[47:32];
      2'd2: rchunk = gdr_pkg::Recip[31:16];
      default: rchunk = gdr_pkg::Recip[15:0];
    endcase
    acc_nx = {acc_q[76:0], 16'd0} + ({47'd0, nn_q} * {77'd0, rchunk});
    quo = acc_q[gdr_pkg::RecipShift +: 32];
    delta = p_q[45] ? (32'd0 - quo) : quo;
    atn = gdr_pkg::atan_lut(bit_q[4:0]);
    xs = cx_q >>> bit_q;
    ys = cy_q >>> bit_q;
  end

  // position plus delta, clamped to the signed PosWidth range
  function automatic logic signed [PosWidth-1:0] sat(
      input logic signed [PosWidth-1:0] a, input logic signed [65:0] b);
    logic signed [66:0] s, hi, lo;
    s  = 67'(a) + 67'(b);
    hi = 67'(signed'({1'b0, {(PosWidth-1){1'b1}}}));
    lo = -hi - 67'sd1;
    if (s > hi) return {1'b0, {(PosWidth-1){1'b1}}};
    if (s < lo) return {1'b1, {(PosWidth-1){1'b0}}};
    return PosWidth'(s);
  endfunction

  // rounded >>30
  function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
    return (v + 66'sd536870912) >>> 30;
  endfunction

  always_comb begin
    dx = rnd(px_q);
    dy = rnd(py_q);
    nx = sat(posx_q, dx);
    ny = sat(posy_q, dy);
  end

  assign q_ready_o    = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign pos_x_o      = ox_q;
  assign pos_y_o      = oy_q;
  assign heading_o    = yaw_q;
  assign tilt_pitch_o = pitch_q;
  assign tilt_roll_o  = roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q <= 2'd0; bit_q <= '0;
      yaw_q <= '0; pitch_q <= '0; roll_q <= '0;
      posx_q <= '0; posy_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          it_q <= q_item_i; ax_q <= 2'd0; state_q <= S_MUL;
        end
        S_MUL: begin
          // 25x21 multiply, *2 folded into the shift
          p_q <= 46'(r_val * signed'({1'b0, it_q.elapsed_us})) <<< 1;
          state_q <= S_DIV; bit_q <= '0;
        end
        S_DIV: begin
          if (bit_q == 6'd0) begin
            nn_q <= mag + 46'd2812; acc_q <= '0; bit_q <= 6'd1;
          end else begin
            acc_q <= acc_nx;
            if (bit_q == 6'd3) state_q <= S_ANG;
            else bit_q <= bit_q + 6'd1;
          end
        end
        S_ANG: begin
          unique case (ax_q)
            2'd0: yaw_q <= cur_ang + delta;
            2'd1: pitch_q <= cur_ang + delta;
            default: roll_q <= cur_ang + delta;
          endcase
          if (ax_q == 2'd2) begin
            state_q <= S_CORD; bit_q <= '0;
            m_q <= 32'((48'(signed'(it_q.distance) * signed'({1'b0, scale_i}))
                        + 48'sd32768) >>> 16);
          end else begin
            ax_q <= ax_q + 2'd1; state_q <= S_MUL;
          end
        end
        S_CORD: begin
          if (bit_q == 6'd0 && ax_q == 2'd2) begin
            // quadrant fold setup
            ax_q <= 2'd3;
            if (yaw_q[31] ^ yaw_q[30]) begin
              cx_q <= -gdr_pkg::CordicGain;
              cz_q <= 33'(signed'(yaw_q - 32'h8000_0000));
            end else begin
              cx_q <= gdr_pkg::CordicGain;
              cz_q <= 33'(signed'(yaw_q));
            end
            cy_q <= '0;
          end else begin
            if (!cz_q[32]) begin
              cx_q <= cx_q - ys; cy_q <= cy_q + xs;
              cz_q <= cz_q - signed'({1'b0, atn});
            end else begin
              cx_q <= cx_q + ys; cy_q <= cy_q - xs;
              cz_q <= cz_q + signed'({1'b0, atn});
            end
            if (bit_q == 6'(Steps - 1)) state_q <= S_PMUL;
            else bit_q <= bit_q + 6'd1;
          end
        end
        S_PMUL: begin
          px_q <= 66'(m_q * cx_q);
          py_q <= 66'(m_q * cy_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          posx_q <= nx; posy_q <= ny;
          ox_q <= 48'(nx); oy_q <= 48'(ny);
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/gyro_dead_reckoning_integrator_top_tb.sv]
// testbench for gyro_dead_reckoning_integrator_top: random and directed gyro requests
// with a behavioral heading and position predictor; depends on gdr_pkg and the design
`timescale 1ns / 1ps

module gyro_dead_reckoning_integrator_top_tb;

  localparam int Steps = 16;
  localparam int Latency = 200;
  localparam int WatchLimit = 40000;

  typedef struct packed {
    logic signed [15:0] rx, ry, rz, dcnt;
    logic [19:0] t;
  } req_t;

  typedef struct packed {
    logic [47:0] px, py;
    logic [31:0] hd, pt, rl;
  } nav_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic cfg_ready_o;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0, distance_i = '0;
  logic [19:0] elapsed_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [47:0] pos_x_o, pos_y_o;
  logic [31:0] heading_o, tilt_pitch_o, tilt_roll_o;

  gyro_dead_reckoning_integrator_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the block registers and state
  logic signed [63:0] bx, by, bz;
  logic [31:0] scale;
  logic [31:0] yaw, pitch, roll;
  logic signed [63:0] posx, posy;

  req_t pending_reqs[$];
  nav_t expected_navs[$];
  int errors = 0;
  bit stim_done = 0;
  bit pause_sender = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] advance_angle(logic [31:0] ang, logic signed [15:0] raw,
                                                logic signed [63:0] bias, logic [19:0] t);
    logic signed [63:0] r, p, mag, q;
    r = 64'(raw) * 256 - bias;
    p = 2 * r * $signed({44'd0, t});
    mag = p < 0 ? -p : p;
    q = (mag + 2812) / 5625;
    if (p < 0) q = -q;
    return ang + q[31:0];
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] pos,
                                                   logic signed [63:0] d);
    logic signed [63:0] hi, lo;
    hi = 64'sd140737488355327;
    lo = -hi - 1;
    if (d > 0 && pos > hi - d) return hi;
    if (d < 0 && pos < lo - d) return lo;
    return pos + d;
  endfunction

  // one update of angles and position, returns the expected output
  function automatic nav_t integrate_nav(req_t q);
    logic signed [63:0] x, y, z, xs, ys, m, c, s;
    logic [31:0] res;
    nav_t n;
    yaw = advance_angle(yaw, q.rz, bz, q.t);
    pitch = advance_angle(pitch, q.rx, bx, q.t);
    roll = advance_angle(roll, q.ry, by, q.t);
    m = (64'(q.dcnt) * $signed({32'd0, scale}) + 32768) >>> 16;
    x = 64'sd652032874;
    y = 0;
    res = yaw;
    // fold the back half-turn onto the front
    if (yaw >= 32'h4000_0000 && yaw < 32'hC000_0000) begin
      x = -x;
      res = yaw - 32'h8000_0000;
    end
    z = 64'($signed(res));
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= 64'(gdr_pkg::atan_lut(5'(i)));
      end else begin
        x = x + ys; y = y - xs; z += 64'(gdr_pkg::atan_lut(5'(i)));
      end
    end
    c = x;
    s = y;
    posx = clamp_add(posx, (m * c + (64'sd1 <<< 29)) >>> 30);
    posy = clamp_add(posy, (m * s + (64'sd1 <<< 29)) >>> 30);
    n.px = posx[47:0];
    n.py = posy[47:0];
    n.hd = yaw;
    n.pt = pitch;
    n.rl = roll;
    return n;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one request at a time from the pending queue
  int send_gap = 0;

  bit in_acc;
  always @(posedge clk_i) in_acc <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    req_t q;
    if (rst_ni) begin
      if (in_acc || !in_valid_i) begin
        if (send_gap > 0 || pause_sender || pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          q = pending_reqs.pop_front();
          expected_navs.push_back(integrate_nav(q));
          rate_x_i <= q.rx; rate_y_i <= q.ry; rate_z_i <= q.rz;
          distance_i <= q.dcnt; elapsed_us_i <= q.t;
          in_valid_i <= 1'b1;
          send_gap <= gap_len();
        end
      end
      out_ready_i <= ($urandom_range(0, 99) < 8) ? 1'b0 : (gap_len() == 0 || out_ready_i);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    nav_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_navs.size() == 0) begin
        $error("unexpected result pos_x=%h", pos_x_o);
        errors++;
      end else begin
        e = expected_navs.pop_front();
        if (pos_x_o !== e.px) begin
          $error("pos_x exp %h got %h", e.px, pos_x_o); errors++;
        end
        if (pos_y_o !== e.py) begin
          $error("pos_y exp %h got %h", e.py, pos_y_o); errors++;
        end
        if (heading_o !== e.hd) begin
          $error("heading exp %h got %h", e.hd, heading_o); errors++;
        end
        if (tilt_pitch_o !== e.pt) begin
          $error("tilt_pitch exp %h got %h", e.pt, tilt_pitch_o); errors++;
        end
        if (tilt_roll_o !== e.rl) begin
          $error("tilt_roll exp %h got %h", e.rl, tilt_roll_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("gyro_dead_reckoning_integrator_top verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_navs.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      gdr_pkg::RegBiasX: bx = 64'($signed(val[23:0]));
      gdr_pkg::RegBiasY: by = 64'($signed(val[23:0]));
      gdr_pkg::RegBiasZ: bz = 64'($signed(val[23:0]));
      gdr_pkg::RegScale: scale = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_req();
    req_t q;
    q.rx = pick16(); q.ry = pick16(); q.rz = pick16(); q.dcnt = pick16();
    case ($urandom_range(0, 5))
      0: q.t = 20'd0;
      1: q.t = 20'hFFFFF;
      2: q.t = 20'($urandom_range(500, 2000));
      default: q.t = 20'($urandom);
    endcase
    return q;
  endfunction

  task automatic run_batch(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
    wait_drained();
  endtask

  initial begin
    req_t q;
    logic [31:0] w;
    bx = -64'sd90409; by = 64'sd16745; bz = 64'sd15683; scale = 32'd4724464;
    yaw = 0; pitch = 0; roll = 0; posx = 0; posy = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero time, quadrant folds
    q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 20'hFFFFF}; pending_reqs.push_back(q);
    q = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 20'hFFFFF}; pending_reqs.push_back(q);
    q = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 20'd0};     pending_reqs.push_back(q);
    q = '{16'shFFFF, 16'sh0001, 16'sh2000, 16'sh8000, 20'd1};     pending_reqs.push_back(q);
    for (int i = 0; i < 8; i++) begin
      q = '{16'sh0000, 16'sh0000, 16'sh6000, 16'sh1234, 20'd900000};
      pending_reqs.push_back(q);
    end
    wait_drained();

    // every register to extremes, out-of-range bits in the biases
    write_reg(gdr_pkg::RegBiasX, 32'hFF80_0000);
    write_reg(gdr_pkg::RegBiasY, 32'h007F_FFFF);
    write_reg(gdr_pkg::RegBiasZ, 32'hA580_0000);
    write_reg(gdr_pkg::RegScale, 32'hFFFF_FFFF);
    // repeat the largest distance at the largest scale
    for (int i = 0; i < 12; i++) begin
      q = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 20'd0};
      pending_reqs.push_back(q);
    end
    wait_drained();
    run_batch(300);

    write_reg(gdr_pkg::RegScale, 32'd0);
    write_reg(gdr_pkg::RegBiasZ, 32'h007F_FFFF);
    run_batch(200);

    // sender holds off mid-batch until every result is in
    for (int i = 0; i < 200; i++) pending_reqs.push_back(random_req());
    repeat (300) @(negedge clk_i);
    pause_sender = 1;
    while (expected_navs.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    pause_sender = 0;
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      w = $urandom;
      write_reg(gdr_pkg::RegBiasX, w);
      write_reg(gdr_pkg::RegBiasY, $urandom);
      write_reg(gdr_pkg::RegBiasZ, $urandom);
      write_reg(gdr_pkg::RegScale, (k % 2) ? $urandom : 32'd4724464);
      run_batch(120);
    end

    if (errors == 0)
      $display("gyro_dead_reckoning_integrator_top verification clean");
    else
      $display("gyro_dead_reckoning_integrator_top verification failed");
    $finish;
  end

endmodule
